/* rtl/gaas_pkg.sv */
package gaas_pkg;
   localparam int MAX_QUERY_DEF = 1024;
   localparam int ALPHABET_DEF  = 24;
   localparam int TAB_DEPTH     = 1024;
   localparam int TAB_AW        = 10;

   localparam logic [1:0] OP_TABLE = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_DB    = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic CSR_GAP_OPEN   = 1'b0;
   localparam logic CSR_GAP_EXTEND = 1'b1;

   localparam logic signed [7:0] S8_MIN = -8'sd128;
   localparam logic signed [7:0] S8_MAX = 8'sd127;

   // Saturate a 10-bit signed value into the 8-bit score range.
   function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
      logic signed [7:0] r;
      if (v < -10'sd128) r = S8_MIN;
      else if (v > 10'sd127) r = S8_MAX;
      else r = v[7:0];
      return r;
   endfunction

   function automatic logic signed [7:0] max8(input logic signed [7:0] a,
                                              input logic signed [7:0] b);
      return (a > b) ? a : b;
   endfunction

   // Column cell record kept per query row.
   typedef struct packed {
      logic signed [7:0] h;
      logic signed [7:0] e;
      logic [7:0]        m;
      logic [7:0]        l;
   } cell_type;
endpackage

/* rtl/global_alignment_affine_stats.sv */
// Global affine-gap alignment score engine. Table loads and query loads are
// written straight into RAM. A database residue sweeps the query column held
// in RAM at one cell per cycle; the first residue of an alignment adds a
// boundary fill pass over every query row. The rate is set by the single read
// and write port of the column RAM. One result item follows the residue marked
// last; a result waiting on the output blocks new items only once the next
// result is ready behind it.
module global_alignment_affine_stats #(
   parameter int MAX_QUERY = gaas_pkg::MAX_QUERY_DEF,
   parameter int ALPHABET  = gaas_pkg::ALPHABET_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [4:0]        req_table_row,
   input  logic [4:0]        req_table_col,
   input  logic signed [7:0] req_table_score,
   input  logic [4:0]        req_residue,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_score,
   output logic signed [7:0] rsp_match_count,
   output logic signed [7:0] rsp_path_length,
   output logic              rsp_saturated,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [6:0]        csr_data
);
   localparam int QW = $clog2(MAX_QUERY);
   localparam int CW = QW + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FILL = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [6:0] open_ff, open_in, ext_ff, ext_in;
   logic [CW-1:0] qcount_ff, qcount_in;
   logic qdone_ff, qdone_in, running_ff, running_in, first_ff, first_in;
   logic sat_ff, sat_in;
   logic signed [7:0] top_ff, top_in, next_top_ff, next_top_in;
   logic [4:0] db_ff, db_in;
   logic last_ff, last_in;
   // Sweep pointers: issue index, fill index, and index of the cell in compute.
   logic [CW-1:0] ridx_ff, ridx_in;
   logic [CW-1:0] fidx_ff, fidx_in;
   logic          vld_ff, vld_in;
   logic [QW-1:0] cidx_ff, cidx_in;
   logic          fin_ff, fin_in;
   logic signed [7:0] diag_h_ff, diag_h_in, f_ff, f_in, fill_h_ff, fill_h_in;
   logic [7:0] diag_m_ff, diag_m_in, diag_l_ff, diag_l_in, fm_ff, fm_in, fl_ff, fl_in;
   gaas_pkg::cell_type fin_cell_ff, fin_cell_in;
   logic out_v_ff, out_v_in;
   logic signed [7:0] o_s_ff, o_s_in, o_m_ff, o_m_in, o_l_ff, o_l_in;
   logic o_sat_ff, o_sat_in;

   logic acc;
   // Input is taken only between sweeps; a finished result waits in ST_DONE.
   assign req_stall = (state_ff != ST_IDLE);
   assign acc = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Memories: table, query, column.
   logic tab_we, q_we, col_we;
   logic [gaas_pkg::TAB_AW-1:0] tab_wa, tab_ra;
   logic [7:0] tab_rd;
   logic [QW-1:0] q_wa, col_wa, rd_a;
   logic [4:0] q_rd;
   gaas_pkg::cell_type col_wd, col_rd;

   gaas_ram #(.WIDTH(8), .DEPTH(gaas_pkg::TAB_DEPTH)) u_tab (
      .clock, .wr_en(tab_we), .wr_addr(tab_wa), .wr_data(req_table_score),
      .rd_addr(tab_ra), .rd_data(tab_rd));
   gaas_ram #(.WIDTH(5), .DEPTH(MAX_QUERY)) u_query (
      .clock, .wr_en(q_we), .wr_addr(q_wa), .wr_data(req_residue),
      .rd_addr(rd_a), .rd_data(q_rd));
   gaas_ram #(.WIDTH($bits(gaas_pkg::cell_type)), .DEPTH(MAX_QUERY)) u_col (
      .clock, .wr_en(col_we), .wr_addr(col_wa), .wr_data(col_wd),
      .rd_addr(rd_a), .rd_data(col_rd));

   // Table read uses the registered query residue read in the cycle before; stage it.
   logic [4:0] q_d_ff;
   logic       qv_ff;
   logic       tok_ff;
   logic [QW-1:0] tidx_ff;
   logic [4:0] q_d_in;
   logic qv_in;
   logic tok_in;
   logic [QW-1:0] tidx_in;
   gaas_pkg::cell_type old_ff, old_in;

   logic in_range;
   logic [9:0] rowcol;
   assign in_range = (32'(db_ff) < ALPHABET) && (32'(q_rd) < ALPHABET);
   assign tab_ra = {db_ff, q_rd};
   assign tab_we = acc && req_opcode == gaas_pkg::OP_TABLE
      && 32'(req_table_row) < ALPHABET && 32'(req_table_col) < ALPHABET;
   assign rowcol = {req_table_row, req_table_col};
   assign tab_wa = rowcol;

   gaas_pkg::cell_type cell_nxt;
   logic signed [7:0] f_nxt;
   logic hit;
   gaas_cell u_cell (
      .diag_h(diag_h_ff), .diag_m(diag_m_ff), .diag_l(diag_l_ff),
      .sub(tok_ff ? tab_rd : 8'sd0), .same(q_d_ff == db_ff),
      .f(f_ff), .f_m(fm_ff), .f_l(fl_ff), .old(old_ff),
      .gap_open(open_ff), .gap_extend(ext_ff),
      .nxt(cell_nxt), .f_nxt(f_nxt), .hit_sat(hit));

   always_comb begin
      state_in = state_ff; open_in = open_ff; ext_in = ext_ff;
      qcount_in = qcount_ff; qdone_in = qdone_ff; running_in = running_ff;
      first_in = first_ff; sat_in = sat_ff; top_in = top_ff;
      next_top_in = next_top_ff; db_in = db_ff; last_in = last_ff;
      ridx_in = ridx_ff; fidx_in = fidx_ff; vld_in = 1'b0; cidx_in = cidx_ff;
      fin_in = 1'b0; diag_h_in = diag_h_ff; f_in = f_ff; fill_h_in = fill_h_ff;
      diag_m_in = diag_m_ff; diag_l_in = diag_l_ff; fm_in = fm_ff; fl_in = fl_ff;
      fin_cell_in = fin_cell_ff; out_v_in = out_v_ff;
      o_s_in = o_s_ff; o_m_in = o_m_ff; o_l_in = o_l_ff; o_sat_in = o_sat_ff;
      q_d_in = q_d_ff; qv_in = 1'b0; tok_in = tok_ff; tidx_in = tidx_ff;
      old_in = old_ff;
      q_we = 1'b0; q_wa = qcount_ff[QW-1:0];
      col_we = 1'b0; col_wa = cidx_ff; col_wd = cell_nxt;
      rd_a = ridx_ff[QW-1:0];

      if (csr_valid && csr_ready) begin
         case (csr_index)
            gaas_pkg::CSR_GAP_OPEN:   open_in = csr_data;
            gaas_pkg::CSR_GAP_EXTEND: ext_in = csr_data;
            default: ;
         endcase
      end
      if (out_v_ff && !rsp_stall) out_v_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               case (req_opcode)
                  gaas_pkg::OP_QUERY: begin
                     if (qdone_ff) begin
                        qcount_in = '0; running_in = 1'b0; q_wa = '0;
                     end
                     if ((qdone_ff ? CW'(0) : qcount_ff) < CW'(MAX_QUERY)) begin
                        q_we = 1'b1;
                        qcount_in = (qdone_ff ? CW'(0) : qcount_ff) + CW'(1);
                     end
                     qdone_in = req_last;
                  end
                  gaas_pkg::OP_DB: begin
                     if (qdone_ff && qcount_ff != '0) begin
                        db_in = req_residue; last_in = req_last;
                        ridx_in = '0; fidx_in = '0;
                        if (!running_ff) begin
                           state_in = ST_FILL; first_in = 1'b1; sat_in = 1'b0;
                           top_in = 8'sd0; running_in = 1'b1;
                           fill_h_in = gaas_pkg::sat8(-10'({1'b0, open_ff}));
                        end else begin
                           state_in = ST_RUN;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL: begin
            // Boundary column written one row per cycle.
            col_we = 1'b1; col_wa = fidx_ff[QW-1:0];
            col_wd.h = fill_h_ff;
            col_wd.e = gaas_pkg::sat8(10'(fill_h_ff) - 10'({1'b0, open_ff}));
            col_wd.m = 8'd0; col_wd.l = 8'd0;
            fill_h_in = gaas_pkg::sat8(10'(fill_h_ff) - 10'({1'b0, ext_ff}));
            fidx_in = fidx_ff + CW'(1);
            if (fidx_ff + CW'(1) == qcount_ff) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (ridx_ff == '0 && !vld_ff && !qv_ff && !fin_ff) begin
               // Column start: set boundaries.
               next_top_in = first_ff ? gaas_pkg::sat8(-10'({1'b0, open_ff}))
                  : gaas_pkg::sat8(10'(top_ff) - 10'({1'b0, ext_ff}));
               diag_h_in = top_ff; diag_m_in = 8'd0; diag_l_in = 8'd0;
               f_in = gaas_pkg::sat8(10'(first_ff
                  ? gaas_pkg::sat8(-10'({1'b0, open_ff}))
                  : gaas_pkg::sat8(10'(top_ff) - 10'({1'b0, ext_ff})))
                  - 10'({1'b0, open_ff}));
               fm_in = 8'd0; fl_in = 8'd0;
            end
            // Stage 0: issue reads of query and column.
            if (ridx_ff < qcount_ff) begin
               ridx_in = ridx_ff + CW'(1);
               qv_in = 1'b1; tidx_in = ridx_ff[QW-1:0];
            end
            // Stage 1: query and column data back; issue table read.
            if (qv_ff) begin
               vld_in = 1'b1; q_d_in = q_rd; tok_in = in_range;
               old_in = col_rd; cidx_in = tidx_ff;
            end
            // Stage 2: compute the cell and write it back.
            if (vld_ff) begin
               col_we = 1'b1;
               diag_h_in = old_ff.h; diag_m_in = old_ff.m; diag_l_in = old_ff.l;
               f_in = f_nxt; fm_in = cell_nxt.m; fl_in = cell_nxt.l;
               if (hit) sat_in = 1'b1;
               if (CW'(cidx_ff) + CW'(1) == qcount_ff) begin
                  fin_in = 1'b1; fin_cell_in = cell_nxt;
               end
            end
            if (fin_ff) begin
               top_in = next_top_ff; first_in = 1'b0;
               state_in = last_ff ? ST_DONE : ST_IDLE;
               if (last_ff) running_in = 1'b0;
            end
         end
         ST_DONE: begin
            if (!out_v_ff) begin
               out_v_in = 1'b1; o_sat_in = sat_ff;
               o_s_in = sat_ff ? gaas_pkg::S8_MAX : fin_cell_ff.h;
               o_m_in = sat_ff ? 8'sd0 : fin_cell_ff.m;
               o_l_in = sat_ff ? 8'sd0 : fin_cell_ff.l;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; open_ff <= 7'd10; ext_ff <= 7'd1;
         qcount_ff <= '0; qdone_ff <= 1'b0; running_ff <= 1'b0;
         first_ff <= 1'b1; sat_ff <= 1'b0; top_ff <= 8'sd0;
         vld_ff <= 1'b0; qv_ff <= 1'b0; fin_ff <= 1'b0; out_v_ff <= 1'b0;
         ridx_ff <= '0; fidx_ff <= '0;
      end else begin
         state_ff <= state_in; open_ff <= open_in; ext_ff <= ext_in;
         qcount_ff <= qcount_in; qdone_ff <= qdone_in; running_ff <= running_in;
         first_ff <= first_in; sat_ff <= sat_in; top_ff <= top_in;
         vld_ff <= vld_in; qv_ff <= qv_in; fin_ff <= fin_in; out_v_ff <= out_v_in;
         ridx_ff <= ridx_in; fidx_ff <= fidx_in;
      end
      next_top_ff <= next_top_in; db_ff <= db_in; last_ff <= last_in;
      cidx_ff <= cidx_in; diag_h_ff <= diag_h_in; f_ff <= f_in;
      fill_h_ff <= fill_h_in; diag_m_ff <= diag_m_in; diag_l_ff <= diag_l_in;
      fm_ff <= fm_in; fl_ff <= fl_in; fin_cell_ff <= fin_cell_in;
      o_s_ff <= o_s_in; o_m_ff <= o_m_in; o_l_ff <= o_l_in; o_sat_ff <= o_sat_in;
      q_d_ff <= q_d_in; tok_ff <= tok_in; tidx_ff <= tidx_in; old_ff <= old_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_score = o_s_ff;
   assign rsp_match_count = o_m_ff;
   assign rsp_path_length = o_l_ff;
   assign rsp_saturated = o_sat_ff;
endmodule

/* rtl/gaas_ram.sv */
module gaas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/gaas_cell.sv */
// One dynamic programming cell: substitution add, three-way choice, gap updates.
module gaas_cell (
   input  logic signed [7:0] diag_h,
   input  logic [7:0]        diag_m,
   input  logic [7:0]        diag_l,
   input  logic signed [7:0] sub,
   input  logic              same,
   input  logic signed [7:0] f,
   input  logic [7:0]        f_m,
   input  logic [7:0]        f_l,
   input  gaas_pkg::cell_type old,
   input  logic [6:0]        gap_open,
   input  logic [6:0]        gap_extend,
   output gaas_pkg::cell_type nxt,
   output logic signed [7:0] f_nxt,
   output logic              hit_sat
);
   logic signed [7:0] d, h, ho;
   logic [7:0] hm, hl;

   always_comb begin
      d = gaas_pkg::sat8(10'(diag_h) + 10'(sub));
      if (d >= f && d >= old.e) begin
         h = d; hm = diag_m + {7'd0, same}; hl = diag_l + 8'd1;
      end else if (f >= old.e) begin
         h = f; hm = f_m; hl = f_l + 8'd1;
      end else begin
         h = old.e; hm = old.m; hl = old.l + 8'd1;
      end
      ho = gaas_pkg::sat8(10'(h) - 10'({1'b0, gap_open}));
      nxt.h = h;
      nxt.m = hm;
      nxt.l = hl;
      nxt.e = gaas_pkg::max8(gaas_pkg::sat8(10'(old.e) - 10'({1'b0, gap_extend})), ho);
      f_nxt = gaas_pkg::max8(gaas_pkg::sat8(10'(f) - 10'({1'b0, gap_extend})), ho);
      hit_sat = (h == gaas_pkg::S8_MIN) || (h == gaas_pkg::S8_MAX);
   end
endmodule

/* rtl/gaas_checker.sv */
module gaas_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic signed [7:0] rsp_score,
   input logic signed [7:0] rsp_match_count,
   input logic signed [7:0] rsp_path_length,
   input logic              rsp_saturated
);
   // A saturated result reports the fixed saturated values.
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_score == 8'sd127
         && rsp_match_count == 8'sd0 && rsp_path_length == 8'sd0)
      else $error("saturated result has wrong fields");
   // A stalled result stays.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_score))
      else $error("stalled result changed");
   // Nothing comes out of reset, and the input is open right after it.
   a_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("result or stall after reset");
endmodule

bind global_alignment_affine_stats gaas_checker u_gaas_checker (.*);
